// File: rtl/ths_pkg.sv
// Shared types and constants for the tag hash set index block.
`timescale 1ns / 1ps

package ths_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HASH_NEW_MODE = 2'd0;
    localparam logic [1:0] CFG_LOG2_SETS     = 2'd1;
    localparam logic [1:0] CFG_LOG2_BANKS    = 2'd2;

    // Widths of the fixed result fields.
    localparam int SET_W  = 16;
    localparam int BANK_W = 8;

    // Largest bank count exponent.
    localparam logic [3:0] MAX_BANK_LOG2 = 4'd8;

    // Candidate sets of one enumeration, and the counter that walks them.
    localparam int CAND   = 8;
    localparam int CAND_W = $clog2(CAND);

    // Request queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Page number field of the I/O address.
    localparam int PAGE_LSB = 12;
    localparam int PAGE_W   = 44;
    localparam int FOLD_SH  = 22;

    // Kind of work a queued request asks of the back.
    typedef enum logic [1:0] {
        ITEM_SET  = 2'd0,
        ITEM_SCAN = 2'd1,
        ITEM_ENUM = 2'd2
    } item_kind_t;

    // Control part of a queued request.
    typedef struct packed {
        item_kind_t          kind;
        logic [CAND_W-1:0]   ctx;
        logic [CAND_W-1:0]   last_c;
    } ent_ctrl_t;

    // Effective configuration after clamping.
    typedef struct packed {
        logic       new_mode;
        logic [4:0] ls;
        logic [3:0] lb;
    } cfg_t;

endpackage

// File: rtl/ths_front.sv
// Front stage: takes requests, hashes the address and classifies the work.
`timescale 1ns / 1ps

module ths_front #(
    parameter int MAX_SET_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ths_pkg::cfg_t                       cfg,
    input  logic                                start,
    output logic                                busy,
    input  logic                                action,
    input  logic [15:0]                         guest_context,
    input  logic [19:0]                         process_context,
    input  logic [63:0]                         io_address,
    input  logic                                q_full,
    output logic                                q_push,
    output logic [$bits(ths_pkg::ent_ctrl_t)+MAX_SET_BITS-1:0] q_wdata
);
    import ths_pkg::*;

    logic                    f_valid_reg;
    logic                    f_valid_next;
    ent_ctrl_t               f_ctrl_reg;
    ent_ctrl_t               f_ctrl_next;
    logic [MAX_SET_BITS-1:0] f_base_reg;
    logic [MAX_SET_BITS-1:0] f_base_next;

    logic                    accept;
    logic [PAGE_W-1:0]       page;
    logic [31:0]             folded;
    logic [127:0]            lv0;
    logic [127:0]            lv1;
    logic [127:0]            lv2;
    logic [CAND_W-1:0]       ctx3;
    logic [CAND_W-1:0]       enum_last;

    // The front blocks only while it holds a request the queue cannot take.
    assign busy   = f_valid_reg && q_full;
    assign accept = start && !busy;
    assign q_push = f_valid_reg && !q_full;
    assign q_wdata = {f_ctrl_reg, f_base_reg};

    // New hash: fold the 44-bit page number onto itself.
    assign page   = io_address[PAGE_LSB +: PAGE_W];
    assign folded = page[31:0] ^ 32'(page[PAGE_W-1:FOLD_SH]);

    // Legacy hash: 128-bit word folded by shifts of 40 and then 20.
    assign lv0 = {48'd0, guest_context, 12'd0, page[31:0], process_context};
    assign lv1 = lv0 ^ (lv0 >> 40);
    assign lv2 = lv1 ^ (lv1 >> 20);

    assign ctx3 = guest_context[CAND_W-1:0] ^ process_context[CAND_W-1:0];

    // Small caches have fewer distinct candidates than contexts.
    always_comb
    begin
        if (cfg.ls >= 5'd3)
        begin
            enum_last = CAND_W'(CAND - 1);
        end
        else
        begin
            enum_last = CAND_W'((4'd1 << cfg.ls) - 4'd1);
        end
    end

    // Classify the incoming request and hold it until the queue has room.
    always_comb
    begin
        f_valid_next = f_valid_reg;
        f_ctrl_next  = f_ctrl_reg;
        f_base_next  = f_base_reg;
        if (q_push)
        begin
            f_valid_next = 1'b0;
        end
        if (accept)
        begin
            f_valid_next       = 1'b1;
            f_ctrl_next.ctx    = '0;
            f_ctrl_next.last_c = '0;
            if (!action)
            begin
                f_ctrl_next.kind = ITEM_SET;
                if (cfg.new_mode)
                begin
                    f_ctrl_next.ctx = ctx3;
                    f_base_next     = MAX_SET_BITS'(folded);
                end
                else
                begin
                    f_base_next = MAX_SET_BITS'(lv2[31:0]);
                end
            end
            else if (cfg.new_mode)
            begin
                f_ctrl_next.kind   = ITEM_ENUM;
                f_ctrl_next.last_c = enum_last;
                f_base_next        = MAX_SET_BITS'(folded);
            end
            else
            begin
                f_ctrl_next.kind = ITEM_SCAN;
                f_base_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_ctrl_reg <= f_ctrl_next;
        f_base_reg <= f_base_next;
    end

endmodule

// File: rtl/ths_queue.sv
// Short request queue between the front and the back.
`timescale 1ns / 1ps

module ths_queue #(
    parameter int WIDTH = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] rdata
);
    import ths_pkg::*;

    logic [WIDTH-1:0]  mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = mem[rd_ptr_reg];

    // Pointer and fill count update; the depth is a power of two.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for queued requests.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/ths_back.sv
// Back stage: places each hash in its bank and walks enumeration candidates.
`timescale 1ns / 1ps

module ths_back #(
    parameter int MAX_SET_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ths_pkg::cfg_t                       cfg,
    input  logic                                q_not_empty,
    input  logic [$bits(ths_pkg::ent_ctrl_t)+MAX_SET_BITS-1:0] q_rdata,
    output logic                                q_pop,
    output logic                                result_valid,
    output logic [ths_pkg::SET_W-1:0]           set_index,
    output logic [ths_pkg::BANK_W-1:0]          bank_id,
    output logic                                full_scan,
    output logic                                last
);
    import ths_pkg::*;

    ent_ctrl_t               h_ctrl;
    logic [MAX_SET_BITS-1:0] h_base;
    logic [CAND_W-1:0]       c_reg;
    logic [CAND_W-1:0]       c_next;
    logic [CAND_W-1:0]       ctx_sel;
    logic [4:0]              sh;
    logic [4:0]              spb_log2;
    logic [MAX_SET_BITS-1:0] ones;
    logic [MAX_SET_BITS-1:0] raw;
    logic [MAX_SET_BITS-1:0] bank_raw;
    logic [MAX_SET_BITS-1:0] in_bank;
    logic [MAX_SET_BITS-1:0] set_raw;
    logic                    final_one;

    logic                    valid_reg;
    logic                    valid_next;
    logic [SET_W-1:0]        set_reg;
    logic [SET_W-1:0]        set_next;
    logic [BANK_W-1:0]       bank_reg;
    logic [BANK_W-1:0]       bank_next;
    logic                    scan_reg;
    logic                    scan_next;
    logic                    last_reg;
    logic                    last_next;

    assign {h_ctrl, h_base} = q_rdata;

    // Context bits go to the top of the set index, unless the cache is tiny.
    assign sh       = (cfg.ls > 5'd3) ? (cfg.ls - 5'd3) : 5'd0;
    assign ctx_sel  = (h_ctrl.kind == ITEM_ENUM) ? c_reg : h_ctrl.ctx;
    assign raw      = (MAX_SET_BITS'(ctx_sel) << sh) ^ h_base;

    // Low bits pick the bank, the bits above them the set inside it.
    assign ones     = '1;
    assign spb_log2 = cfg.ls - {1'b0, cfg.lb};
    assign bank_raw = raw & ~(ones << cfg.lb);
    assign in_bank  = (raw >> cfg.lb) & ~(ones << spb_log2);
    assign set_raw  = (bank_raw << spb_log2) | in_bank;

    assign final_one = (c_reg == h_ctrl.last_c);
    assign q_pop     = q_not_empty && final_one;

    // One result per cycle; the candidate counter steps through enumerations.
    always_comb
    begin
        c_next     = c_reg;
        valid_next = q_not_empty;
        set_next   = set_reg;
        bank_next  = bank_reg;
        scan_next  = scan_reg;
        last_next  = last_reg;
        if (q_not_empty)
        begin
            c_next    = final_one ? '0 : (c_reg + 1'b1);
            last_next = final_one;
            if (h_ctrl.kind == ITEM_SCAN)
            begin
                set_next  = '0;
                bank_next = '0;
                scan_next = 1'b1;
            end
            else
            begin
                set_next  = SET_W'(set_raw);
                bank_next = BANK_W'(bank_raw);
                scan_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            c_reg     <= c_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg  <= set_next;
        bank_reg <= bank_next;
        scan_reg <= scan_next;
        last_reg <= last_next;
    end

    assign result_valid = valid_reg;
    assign set_index    = set_reg;
    assign bank_id      = bank_reg;
    assign full_scan    = scan_reg;
    assign last         = last_reg;

endmodule

// File: rtl/tag_hash_set_index.sv
// Top level of the translation cache set index hash.
//
// Requests enter on start while busy is low: a compute request (action 0)
// returns the set that a context pair and I/O address hash to; an enumerate
// request (action 1) returns every distinct set the address may map to under
// any context, or a single full_scan result in legacy hash mode.
// Results appear on set_index, bank_id, full_scan and last for one cycle,
// marked by result_valid; last flags the final result of a request.
// The receiver cannot stall, so results are never held.
// With an empty queue a request reaches its first result through the front
// register, the queue and the output register.
// Throughput: one compute request per cycle while busy is low. An enumerate
// request occupies the output sequencer for one result per distinct set, up
// to eight, or one result in legacy mode; a four-entry queue absorbs requests
// meanwhile and busy rises only when both queue and front register are full.
// Configuration is written through cfg_write, cfg_index and cfg_data, at once.
// Reset sets the new hash mode, 512 sets and one bank, and empties the queue.
`timescale 1ns / 1ps

module tag_hash_set_index #(
    parameter int MAX_SET_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [4:0]                    cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [15:0]                   guest_context,
    input  logic [19:0]                   process_context,
    input  logic [63:0]                   io_address,
    output logic                          result_valid,
    output logic [ths_pkg::SET_W-1:0]     set_index,
    output logic [ths_pkg::BANK_W-1:0]    bank_id,
    output logic                          full_scan,
    output logic                          last
);
    import ths_pkg::*;

    localparam int QW = $bits(ent_ctrl_t) + MAX_SET_BITS;

    logic          mode_reg;
    logic [4:0]    sets_reg;
    logic [3:0]    banks_reg;
    logic [3:0]    banks_sat;
    cfg_t          cfg;

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_not_empty;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b1;
            sets_reg  <= 5'd9;
            banks_reg <= 4'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HASH_NEW_MODE: mode_reg  <= cfg_data[0];
                CFG_LOG2_SETS:     sets_reg  <= cfg_data;
                CFG_LOG2_BANKS:    banks_reg <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    // Clamp the set and bank counts to what the design can hold.
    assign banks_sat    = (banks_reg > MAX_BANK_LOG2) ? MAX_BANK_LOG2 : banks_reg;
    assign cfg.new_mode = mode_reg;
    assign cfg.ls       = (sets_reg > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : sets_reg;
    assign cfg.lb       = ({1'b0, banks_sat} > cfg.ls) ? cfg.ls[3:0] : banks_sat;

    ths_front #(
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .guest_context   (guest_context),
        .process_context (process_context),
        .io_address      (io_address),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_wdata         (q_wdata)
    );

    ths_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    ths_back #(
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_not_empty  (q_not_empty),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .set_index    (set_index),
        .bank_id      (bank_id),
        .full_scan    (full_scan),
        .last         (last)
    );

endmodule

// File: rtl/ths_checker.sv
// Port-level checks for the set index hash, bound to the top level.
`timescale 1ns / 1ps

module ths_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       result_valid,
    input logic [ths_pkg::SET_W-1:0]  set_index,
    input logic [ths_pkg::BANK_W-1:0] bank_id,
    input logic                       full_scan,
    input logic                       last
);
    import ths_pkg::*;

    // A full scan result is the only result of its request and carries no set.
    a_scan_alone: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && full_scan |-> last && set_index == '0 && bank_id == '0)
        else $error("full scan result with set or without last");

    // Results of one enumeration follow one another without a gap.
    a_enum_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("gap inside an enumeration burst");

    // Busy rises only after a request has been taken.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

endmodule

bind tag_hash_set_index ths_checker u_ths_checker (.*);

// File: tb/tb_tag_hash_set_index.sv
// Self-checking testbench for the tag hash set index block.
`timescale 1ns / 1ps

import ths_pkg::*;

// Largest set count exponent the block is built for.
localparam int SET_BITS_CAP = 16;

// Request actions.
localparam logic ACT_COMPUTE   = 1'b0;
localparam logic ACT_ENUMERATE = 1'b1;

// Register index past the last real register; writes to it must be ignored.
localparam logic [1:0] CFG_UNUSED = 2'd3;

// One expected result of a request.
typedef struct {
    logic [15:0] set_index;
    logic [7:0]  bank_id;
    logic        full_scan;
    logic        last;
} set_result_t;

// Mirrors the register file, predicts the sets of every taken request and
// checks the results in order against them.
class set_scoreboard;
    logic        new_mode;
    logic [4:0]  sets_reg;
    logic [3:0]  banks_reg;
    set_result_t pending_sets[$];
    int          errors;

    function new();
        new_mode  = 1'b1;
        sets_reg  = 5'd9;
        banks_reg = 4'd0;
        errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [4:0] data);
        case (idx)
            CFG_HASH_NEW_MODE: new_mode  = data[0];
            CFG_LOG2_SETS:     sets_reg  = data;
            CFG_LOG2_BANKS:    banks_reg = data[3:0];
            default:           ;
        endcase
    endfunction

    function int unsigned sets_log2();
        return (sets_reg > SET_BITS_CAP) ? SET_BITS_CAP : sets_reg;
    endfunction

    function int unsigned banks_log2();
        int unsigned lb;
        lb = (banks_reg > 4'd8) ? 8 : banks_reg;
        return (lb > sets_log2()) ? sets_log2() : lb;
    endfunction

    // Page number folded onto itself by 22 bits.
    function logic [31:0] fold_page(logic [63:0] addr);
        logic [43:0] pn;
        logic [43:0] f;
        pn = addr[55:12];
        f  = pn ^ (pn >> 22);
        return f[31:0];
    endfunction

    // New hash: three context bits placed at the top of the set index.
    function logic [31:0] mix_context(logic [2:0] ctx, logic [31:0] folded);
        int unsigned ls;
        int unsigned sh;
        logic [31:0] mask;
        ls   = sets_log2();
        sh   = (ls > 3) ? ls - 3 : 0;
        mask = (32'd1 << ls) - 32'd1;
        return ((32'(ctx) << sh) ^ folded) & mask;
    endfunction

    // Legacy hash: 128-bit concatenation folded by 40 and then by 20 bits.
    function logic [31:0] legacy_fold(logic [15:0] g, logic [19:0] p, logic [63:0] addr);
        logic [127:0] v;
        logic [127:0] v1;
        logic [127:0] v2;
        v  = {48'd0, g, 12'd0, addr[43:12], p};
        v1 = v ^ (v >> 40);
        v2 = v1 ^ (v1 >> 20);
        return v2[31:0];
    endfunction

    // Split a raw hash into bank and set within the bank.
    function void place(input logic [31:0] raw, output logic [15:0] s, output logic [7:0] b);
        int unsigned ls;
        int unsigned lb;
        int unsigned spb_log2;
        logic [31:0] bank_no;
        logic [31:0] in_bank;
        logic [31:0] glob;
        ls       = sets_log2();
        lb       = banks_log2();
        spb_log2 = ls - lb;
        if (lb == 0)
        begin
            glob = raw & ((32'd1 << ls) - 32'd1);
            s    = glob[15:0];
            b    = 8'd0;
        end
        else
        begin
            bank_no = raw & ((32'd1 << lb) - 32'd1);
            in_bank = (raw >> lb) & ((32'd1 << spb_log2) - 32'd1);
            glob    = (bank_no << spb_log2) + in_bank;
            s       = glob[15:0];
            b       = bank_no[7:0];
        end
    endfunction

    // Work out the results of a request taken by the block.
    function void note_request(logic act, logic [15:0] g, logic [19:0] p, logic [63:0] addr);
        set_result_t r;
        logic [31:0] raw;
        logic [31:0] folded;
        logic [15:0] s;
        logic [7:0]  b;
        logic [15:0] cand_sets[8];
        logic [7:0]  cand_banks[8];
        int          count;
        bit          dup;
        if (act == ACT_COMPUTE)
        begin
            raw = new_mode ? mix_context(g[2:0] ^ p[2:0], fold_page(addr))
                           : legacy_fold(g, p, addr);
            place(raw, s, b);
            r = '{set_index: s, bank_id: b, full_scan: 1'b0, last: 1'b1};
            pending_sets.push_back(r);
        end
        else if (!new_mode)
        begin
            // Legacy hash cannot list its sets, so the cache must be scanned.
            r = '{set_index: 16'd0, bank_id: 8'd0, full_scan: 1'b1, last: 1'b1};
            pending_sets.push_back(r);
        end
        else
        begin
            // Every context value in turn, keeping the first of each set.
            folded = fold_page(addr);
            count  = 0;
            for (int c = 0; c < 8; c++)
            begin
                place(mix_context(3'(c), folded), s, b);
                dup = 1'b0;
                for (int i = 0; i < count; i++)
                    if (cand_sets[i] == s)
                        dup = 1'b1;
                if (!dup)
                begin
                    cand_sets[count]  = s;
                    cand_banks[count] = b;
                    count++;
                end
            end
            for (int i = 0; i < count; i++)
            begin
                r = '{set_index: cand_sets[i], bank_id: cand_banks[i], full_scan: 1'b0,
                      last: (i == count - 1)};
                pending_sets.push_back(r);
            end
        end
    endfunction

    function void check_result(logic [15:0] s, logic [7:0] b, logic fs, logic lst);
        set_result_t e;
        if (pending_sets.size() == 0)
        begin
            $error("unexpected result: set_index %0d bank_id %0d", s, b);
            errors++;
            return;
        end
        e = pending_sets.pop_front();
        if (s !== e.set_index)
        begin
            $error("set_index: expected %0d, actual %0d", e.set_index, s);
            errors++;
        end
        if (b !== e.bank_id)
        begin
            $error("bank_id: expected %0d, actual %0d", e.bank_id, b);
            errors++;
        end
        if (fs !== e.full_scan)
        begin
            $error("full_scan: expected %0b, actual %0b", e.full_scan, fs);
            errors++;
        end
        if (lst !== e.last)
        begin
            $error("last: expected %0b, actual %0b", e.last, lst);
            errors++;
        end
    endfunction

    function int pending();
        return pending_sets.size();
    endfunction
endclass

module tb_tag_hash_set_index;

    // Cycles with neither a request taken nor a result shown before giving up.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 30;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_data;
    logic        start;
    logic        busy;
    logic        action;
    logic [15:0] guest_context;
    logic [19:0] process_context;
    logic [63:0] io_address;
    logic        result_valid;
    logic [15:0] set_index;
    logic [7:0]  bank_id;
    logic        full_scan;
    logic        last;

    set_scoreboard sb;
    int            stall_count;

    tag_hash_set_index #(
        .MAX_SET_BITS(SET_BITS_CAP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .action(action),
        .guest_context(guest_context),
        .process_context(process_context),
        .io_address(io_address),
        .result_valid(result_valid),
        .set_index(set_index),
        .bank_id(bank_id),
        .full_scan(full_scan),
        .last(last)
    );

    // Clock, 4 ns period.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sample both sides at the rising edge and keep the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result(set_index, bank_id, full_scan, last);
            if (cfg_write)
                sb.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_request(action, guest_context, process_context, io_address);
            if ((start && !busy) || result_valid)
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Present a request and hold it until the block takes it.
    task automatic send_request(logic act, logic [15:0] g, logic [19:0] p, logic [63:0] addr);
        @(negedge clk);
        start           = 1'b1;
        action          = act;
        guest_context   = g;
        process_context = p;
        io_address      = addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random_request();
        logic [63:0] addr;
        addr = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0: addr = '0;
            1: addr = '1;
            default: ;
        endcase
        send_request(1'($urandom_range(0, 1)), 16'($urandom), 20'($urandom), addr);
    endtask

    task automatic pause_requests(int unsigned n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    // Wait until every predicted result has been seen.
    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_config(logic mode, logic [4:0] ls, logic [4:0] lb);
        wait_drained();
        write_reg(CFG_HASH_NEW_MODE, {4'd0, mode});
        write_reg(CFG_LOG2_SETS, ls);
        write_reg(CFG_LOG2_BANKS, lb);
    endtask

    // Extremes of the fields and each special case under chosen settings.
    task automatic run_directed();
        // Reset settings: new hash, 512 sets, one bank.
        send_request(ACT_COMPUTE, 16'h0000, 20'h00000, 64'h0);
        send_request(ACT_COMPUTE, 16'hFFFF, 20'hFFFFF, '1);
        send_request(ACT_ENUMERATE, 16'hFFFF, 20'hFFFFF, '1);
        send_request(ACT_COMPUTE, 16'hFFFF, 20'h00000, 64'hAAAA_5555_AAAA_5555);
        // Legacy hash, including the full scan answer to an enumerate.
        wait_drained();
        write_reg(CFG_HASH_NEW_MODE, 5'd0);
        send_request(ACT_COMPUTE, 16'hFFFF, 20'hFFFFF, '1);
        send_request(ACT_COMPUTE, 16'h0000, 20'h00000, 64'h0);
        send_request(ACT_ENUMERATE, 16'h1234, 20'h56789, '1);
        // A write to the unused index must leave the settings alone.
        wait_drained();
        write_reg(CFG_UNUSED, 5'd31);
        send_request(ACT_COMPUTE, 16'h0000, 20'hFFFFF, 64'h5555_AAAA_5555_AAAA);
        // Oversized set and bank counts saturate.
        set_config(1'b1, 5'd31, 5'd15);
        send_request(ACT_COMPUTE, 16'hFFFF, 20'hFFFFF, '1);
        send_request(ACT_ENUMERATE, 16'h0000, 20'h00000, '1);
        // Small cache: context bits stay unshifted and banks clamp to sets.
        set_config(1'b1, 5'd3, 5'd8);
        send_request(ACT_COMPUTE, 16'($urandom), 20'($urandom), {$urandom, $urandom});
        send_request(ACT_ENUMERATE, 16'($urandom), 20'($urandom), {$urandom, $urandom});
        // A single set: every candidate collapses onto one.
        set_config(1'b1, 5'd0, 5'd0);
        send_request(ACT_COMPUTE, 16'hFFFF, 20'hFFFFF, '1);
        send_request(ACT_ENUMERATE, 16'hFFFF, 20'hFFFFF, '1);
        // Largest legacy cache with the most banks.
        set_config(1'b0, 5'd16, 5'd8);
        send_request(ACT_COMPUTE, 16'hFFFF, 20'hFFFFF, '1);
        send_request(ACT_COMPUTE, 16'($urandom), 20'($urandom), {$urandom, $urandom});
        // Single bank with new hash.
        set_config(1'b1, 5'd12, 5'd0);
        send_request(ACT_ENUMERATE, 16'($urandom), 20'($urandom), {$urandom, $urandom});
        send_request(ACT_COMPUTE, 16'($urandom), 20'($urandom), {$urandom, $urandom});
    endtask

    initial
    begin
        int unsigned idle_odds;
        logic [4:0]  ls;
        sb              = new();
        stall_count     = 0;
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = CFG_HASH_NEW_MODE;
        cfg_data        = 5'd0;
        start           = 1'b0;
        action          = ACT_COMPUTE;
        guest_context   = 16'd0;
        process_context = 20'd0;
        io_address      = 64'd0;
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        // Random phases: the first few at fixed extremes, the rest at random.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: set_config(1'b1, 5'd16, 5'd8);
                1: set_config(1'b0, 5'd16, 5'd8);
                2: set_config(1'b1, 5'd0, 5'd0);
                3: set_config(1'b1, 5'd4, 5'd31);
                default:
                begin
                    ls = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                                     : 5'($urandom_range(0, 16));
                    set_config(1'($urandom_range(0, 1)), ls, 5'($urandom_range(0, 31)));
                    if ($urandom_range(0, 3) == 0)
                        write_reg(CFG_UNUSED, 5'($urandom));
                end
            endcase
            // No idling in the closing phase; elsewhere a random density.
            idle_odds = (ph == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_random_request();
                if (idle_odds != 0 && $urandom_range(1, 4) <= idle_odds)
                    pause_requests($urandom_range(1, 13));
            end
        end

        // Drain, then allow for any stray result behind the last one.
        wait_drained();
        repeat (8)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ths_pkg.sv
rtl/ths_front.sv
rtl/ths_queue.sv
rtl/ths_back.sv
rtl/tag_hash_set_index.sv
rtl/ths_checker.sv
tb/tb_tag_hash_set_index.sv
